// File: design/fud_pkg.sv
// ----------------------------------------------------------------------------
// fud_pkg
// Shared types, character codes and helpers for the form-urlencoded decoder.
// ----------------------------------------------------------------------------
package fud_pkg;

  localparam int unsigned ByteW = 8;

  typedef enum logic [1:0] {
    KIND_KEY   = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_END   = 2'd2
  } kind_e;

  localparam logic [ByteW-1:0] CHAR_AMP     = 8'h26;
  localparam logic [ByteW-1:0] CHAR_PLUS    = 8'h2B;
  localparam logic [ByteW-1:0] CHAR_PERCENT = 8'h25;
  localparam logic [ByteW-1:0] CHAR_EQUALS  = 8'h3D;
  localparam logic [ByteW-1:0] CHAR_SPACE   = 8'h20;

  // escape length in characters
  localparam logic [1:0] ESC_LEN = 2'd2;

  typedef struct packed {
    logic             last;
    logic [ByteW-1:0] data;
  } item_t;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] data;
  } result_t;

  typedef struct packed {
    logic       in_value;
    logic [1:0] escape_left;
  } status_t;

  // digit value in the low bits, bit 4 set for a non-hex character
  function automatic logic [4:0] hex_digit(input logic [ByteW-1:0] c);
    logic [4:0] d;
    d = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = 5'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = 5'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = 5'(c - 8'h37);
    end
    return d;
  endfunction

endpackage

// File: design/form_urlencoded_decoder_core.sv
// Decodes an application/x-www-form-urlencoded byte stream, one byte per
// transfer, into key bytes, value bytes and end-of-pair markers. It takes one
// byte every clock cycle when the output side keeps up; each byte passes an
// input register and a result register. The result is offered once its byte
// has moved on from the input register into the result register. A full
// result register that the sink does not take holds the input register, and
// the input then stalls. Bytes that produce no result ('=' in key phase, '%'
// in value phase and the first escape character) leave the result register
// empty for that slot.
// ----------------------------------------------------------------------------
// form_urlencoded_decoder_core
// Top level: input register, decode state and logic, result register.
// ----------------------------------------------------------------------------
module form_urlencoded_decoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // ends_stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [1:0] m_axis_tuser    // [1:0] kind
);
  import fud_pkg::*;

  item_t   in_item;
  item_t   stage_item;
  logic    stage_valid;
  logic    out_free;
  logic    advance;
  logic    emit;
  result_t result;
  result_t out_result;
  status_t status;

  assign in_item.data = s_axis_tdata;
  assign in_item.last = s_axis_tlast;
  assign advance      = stage_valid && out_free;

  fud_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .item_i    (in_item),
    .advance_i (advance),
    .valid_o   (stage_valid),
    .item_o    (stage_item)
  );

  fud_decoder u_decoder (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (stage_item),
    .emit_o   (emit),
    .result_o (result),
    .status_o (status)
  );

  fud_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance),
    .emit_i   (emit),
    .result_i (result),
    .free_o   (out_free),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (out_result)
  );

  assign m_axis_tdata = out_result.data;
  assign m_axis_tuser = out_result.kind;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == KIND_KEY || m_axis_tuser == KIND_VALUE ||
                       m_axis_tuser == KIND_END))
    else $error("invalid result kind");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == KIND_END) |-> (m_axis_tdata == '0))
    else $error("end-of-pair marker with nonzero byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.escape_left != 2'd3)
    else $error("escape count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && stage_item.last) |=> (!status.in_value && status.escape_left == 2'd0))
    else $error("state not cleared after end of stream");
`endif

endmodule

// File: design/fud_in_reg.sv
// ----------------------------------------------------------------------------
// fud_in_reg
// Input register stage: captures one transfer and holds it until decoded.
// ----------------------------------------------------------------------------
module fud_in_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  fud_pkg::item_t item_i,
  input  logic          advance_i,
  output logic          valid_o,
  output fud_pkg::item_t item_o
);
  import fud_pkg::*;

  logic  valid_q;
  logic  valid_d;
  item_t item_q;

  assign ready_o = !valid_q || advance_i;
  assign valid_d = (valid_i && ready_o) || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: design/fud_decoder.sv
// ----------------------------------------------------------------------------
// fud_decoder
// Phase and escape state with the per-byte decode logic.
// ----------------------------------------------------------------------------
module fud_decoder (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  fud_pkg::item_t   item_i,
  output logic             emit_o,
  output fud_pkg::result_t result_o,
  output fud_pkg::status_t status_o
);
  import fud_pkg::*;

  logic             in_value_q, in_value_d;
  logic [1:0]       esc_q, esc_d;
  logic [ByteW-1:0] acc_q, acc_d;
  logic             stopped_q, stopped_d;
  logic [4:0]       digit;
  logic             emit;
  result_t          result;

  assign digit = hex_digit(item_i.data);

  always_comb begin
    in_value_d  = in_value_q;
    esc_d       = esc_q;
    acc_d       = acc_q;
    stopped_d   = stopped_q;
    emit        = 1'b0;
    result.data = '0;
    result.kind = KIND_KEY;
    if (!in_value_q) begin
      if (item_i.data == CHAR_EQUALS) begin
        in_value_d = 1'b1;
      end else begin
        emit        = 1'b1;
        result.data = item_i.data;
        result.kind = KIND_KEY;
      end
    end else if (item_i.data == CHAR_AMP) begin
      esc_d       = 2'd0;
      in_value_d  = 1'b0;
      emit        = 1'b1;
      result.kind = KIND_END;
    end else if (esc_q != 2'd0) begin
      if (!stopped_q) begin
        if (!digit[4]) begin
          acc_d = {acc_q[3:0], digit[3:0]};
        end else begin
          stopped_d = 1'b1;
        end
      end
      esc_d = esc_q - 2'd1;
      if (esc_q == 2'd1) begin
        emit        = 1'b1;
        result.data = acc_d;
        result.kind = KIND_VALUE;
      end
    end else if (item_i.data == CHAR_PERCENT) begin
      esc_d     = ESC_LEN;
      acc_d     = '0;
      stopped_d = 1'b0;
    end else if (item_i.data == CHAR_PLUS) begin
      emit        = 1'b1;
      result.data = CHAR_SPACE;
      result.kind = KIND_VALUE;
    end else begin
      emit        = 1'b1;
      result.data = item_i.data;
      result.kind = KIND_VALUE;
    end
    // end of stream resets phase and drops a pending escape
    if (item_i.last) begin
      in_value_d = 1'b0;
      esc_d      = 2'd0;
      acc_d      = '0;
      stopped_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_value_q <= 1'b0;
      esc_q      <= 2'd0;
      acc_q      <= '0;
      stopped_q  <= 1'b0;
    end else if (step_i) begin
      in_value_q <= in_value_d;
      esc_q      <= esc_d;
      acc_q      <= acc_d;
      stopped_q  <= stopped_d;
    end
  end

  assign emit_o               = emit;
  assign result_o             = result;
  assign status_o.in_value    = in_value_q;
  assign status_o.escape_left = esc_q;

endmodule

// File: design/fud_out_reg.sv
// ----------------------------------------------------------------------------
// fud_out_reg
// Result register: holds a decoded byte until the downstream transfer.
// ----------------------------------------------------------------------------
module fud_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic             emit_i,
  input  fud_pkg::result_t result_i,
  output logic             free_o,
  output logic             valid_o,
  input  logic             ready_i,
  output fud_pkg::result_t result_o
);
  import fud_pkg::*;

  logic    valid_q;
  logic    valid_d;
  result_t result_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i ? emit_i : (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && emit_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule
